>>> rtl/core/wcfp_pkg.sv
// shared types, character codes and constants of the wave command frame parser
// no dependencies; imported by every module of the parser
package wcfp_pkg;

  localparam int NUM_FIELDS  = 5;
  localparam int FIELD_IDX_W = 3;
  localparam int MAG_W       = 17;
  localparam int CODE_W      = 4;
  localparam int CFG_IDX_W   = 1;

  localparam int LEVEL_CHARS_DEF = 3;
  localparam int FREQ_CHARS_DEF  = 5;

  // index value that means "past the last field"
  localparam logic [FIELD_IDX_W-1:0] FIELD_PAST = 3'd5;

  localparam logic [MAG_W-1:0] MAG_MAX = 17'h1FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CODE = 1'b1;

  localparam logic [CODE_W-1:0] FIRST_CODE_RST  = 4'd1;
  localparam logic [CODE_W-1:0] SECOND_CODE_RST = 4'd2;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic              neg;
    logic [MAG_W-1:0]  mag;
  } field_parse_t;

  localparam field_parse_t FIELD_CLEAR = '{phase: PH_SKIP, neg: 1'b0, mag: '0};

endpackage

>>> rtl/core/wcfp_char_feed.sv
// atoi-style update of one field's parse state by one character
// depends on wcfp_pkg
module wcfp_char_feed (
  input  logic [7:0]            ch,
  input  wcfp_pkg::field_parse_t cur,
  output wcfp_pkg::field_parse_t upd
);
  import wcfp_pkg::*;

  logic              is_digit;
  logic              is_blank;
  logic              is_sign;
  logic [3:0]        digit;
  logic [MAG_W+3:0]  prod;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign digit    = 4'(ch - CH_ZERO);

  // mag * 10 + digit as shift-add
  assign prod = ({4'b0, cur.mag} << 3) + ({4'b0, cur.mag} << 1) + (MAG_W+4)'(digit);

  always_comb begin
    upd = cur;
    priority if (cur.phase == PH_DONE) begin
      upd = cur;
    end else if (is_digit) begin
      upd.mag   = (prod > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : prod[MAG_W-1:0];
      upd.phase = PH_DIGITS;
    end else if ((cur.phase == PH_SKIP) && is_blank) begin
      upd = cur;
    end else if ((cur.phase == PH_SKIP) && is_sign) begin
      upd.neg   = (ch == CH_MINUS);
      upd.phase = PH_SIGN;
    end else begin
      upd.phase = PH_DONE;
    end
  end

endmodule

>>> rtl/core/wcfp_fields.sv
// field index and the five field accumulators, one shared feed unit
// depends on wcfp_pkg and wcfp_char_feed
module wcfp_fields #(
  parameter int LevelChars = wcfp_pkg::LEVEL_CHARS_DEF,
  parameter int FreqChars  = wcfp_pkg::FREQ_CHARS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             ch,
  output wcfp_pkg::field_parse_t fields [wcfp_pkg::NUM_FIELDS]
);
  import wcfp_pkg::*;

  localparam int MaxChars = (LevelChars > FreqChars) ? LevelChars : FreqChars;
  localparam int CntW     = $clog2(MaxChars + 1);
  localparam logic [CntW-1:0] Cap [NUM_FIELDS] = '{
    CntW'(1), CntW'(1), CntW'(LevelChars), CntW'(LevelChars), CntW'(FreqChars)
  };

  logic [FIELD_IDX_W-1:0] field_index, field_index_next;
  logic [CntW-1:0]        count      [NUM_FIELDS];
  logic [CntW-1:0]        count_next [NUM_FIELDS];
  field_parse_t           parse      [NUM_FIELDS];
  field_parse_t           parse_next [NUM_FIELDS];

  field_parse_t     feed_in, feed_out;
  logic [CntW-1:0]  cnt_sel;
  logic [CntW-1:0]  cap_sel;
  logic             in_range;

  wcfp_char_feed u_feed (
    .ch  (ch),
    .cur (feed_in),
    .upd (feed_out)
  );

  // select the current field for the shared feed unit
  always_comb begin
    feed_in = parse[0];
    cnt_sel = count[0];
    cap_sel = Cap[0];
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (field_index == FIELD_IDX_W'(i)) begin
        feed_in = parse[i];
        cnt_sel = count[i];
        cap_sel = Cap[i];
      end
    end
  end

  assign in_range = field_index < FIELD_PAST;

  always_comb begin
    field_index_next = field_index;
    parse_next       = parse;
    count_next       = count;
    if (step) begin
      priority if (ch == CH_OPEN) begin
        field_index_next = '0;
      end else if (ch == CH_COMMA) begin
        if (in_range) field_index_next = field_index + 1'b1;
      end else if (ch == CH_CLOSE) begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
          parse_next[i] = FIELD_CLEAR;
          count_next[i] = '0;
        end
      end else if ((ch != CH_NUL) && in_range && (cnt_sel < cap_sel)) begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
          if (field_index == FIELD_IDX_W'(i)) begin
            parse_next[i] = feed_out;
            count_next[i] = cnt_sel + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index <= '0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        parse[i] <= FIELD_CLEAR;
        count[i] <= '0;
      end
    end else begin
      field_index <= field_index_next;
      parse       <= parse_next;
      count       <= count_next;
    end
  end

  assign fields = parse;

`ifndef ASSERT_OFF
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    field_index <= FIELD_PAST)
    else $error("field index beyond the past-last marker");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (step && (ch == CH_CLOSE)) |=> (count[0] == '0) && (count[1] == '0) &&
      (count[2] == '0) && (count[3] == '0) && (count[4] == '0))
    else $error("fields not cleared after frame end");

  a_freq_capacity: assert property (@(posedge clk) disable iff (rst)
    (count[4] <= CntW'(FreqChars)) && (count[0] <= CntW'(1)))
    else $error("field character count above capacity");
`endif

endmodule

>>> rtl/core/wave_command_frame_parser_core.sv
// top level of the wave command frame parser: input register, field parser,
// channel match and result register; depends on wcfp_pkg and wcfp_fields
//
// usage
//   input channel: rx_char with in_valid / in_stall, one character per
//   transaction. output channel: wave_* fields with out_valid / out_stall,
//   one transaction per '>' whose channel field matches a configured code
//   (first code wins when both match); other frames end silently.
//   configuration: cfg_write with cfg_index (0 first code, 1 second code)
//   and cfg_data; the user must write while the block is idle (not enforced).
//   throughput: one character per cycle unless a '>' waits on a stall. the
//   input register holds the character while the field accumulator updates,
//   one field per character through a single multiply-by-ten-and-add unit.
//   path: an accepted '>' is held in the input register, then its result
//   goes into the result register once that register is free.
//   stall: while a result waits in the result register, characters other
//   than '>' keep flowing; a '>' waits in the input register until the
//   result is taken, and in_stall is raised only while such a '>' waits.
//   reset: synchronous; field index and fields cleared, codes back to 1
//   and 2, no result pending; no clearing pass is needed
module wave_command_frame_parser_core #(
  parameter int LevelChars = wcfp_pkg::LEVEL_CHARS_DEF,
  parameter int FreqChars  = wcfp_pkg::FREQ_CHARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_write,
  input  logic [wcfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wcfp_pkg::CODE_W-1:0]      cfg_data,
  // character input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       rx_char,
  // parsed command output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             wave_select,
  output logic [3:0]                       wave_type,
  output logic [7:0]                       wave_amplitude,
  output logic [7:0]                       wave_offset,
  output logic signed [17:0]               wave_frequency
);
  import wcfp_pkg::*;

  // configuration registers
  logic [CODE_W-1:0] first_code;
  logic [CODE_W-1:0] second_code;

  // input register
  logic       in_full, in_full_next;
  logic [7:0] rx_char_r;

  // processing control
  logic step;
  logic is_close;
  logic out_free;
  logic in_accept;

  field_parse_t fields [NUM_FIELDS];

  // decoded frame values
  logic [7:0]  chan_val;
  logic        hit_first;
  logic        hit_second;
  logic        emit;
  logic [3:0]  type_val;
  logic [7:0]  amp_val;
  logic [7:0]  off_val;
  logic [17:0] freq_val;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_code  <= FIRST_CODE_RST;
      second_code <= SECOND_CODE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FIRST_CODE:  first_code  <= cfg_data;
        CFG_SECOND_CODE: second_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // a '>' needs room in the result register, every other character moves on
  assign is_close  = (rx_char_r == CH_CLOSE);
  assign out_free  = !out_valid || !out_stall;
  assign step      = in_full && (!is_close || out_free);
  assign in_stall  = in_full && !step;
  assign in_accept = in_valid && !in_stall;

  assign in_full_next = in_accept ? 1'b1 : (step ? 1'b0 : in_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rx_char_r <= rx_char;
    end
  end

  wcfp_fields #(
    .LevelChars (LevelChars),
    .FreqChars  (FreqChars)
  ) u_fields (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .ch     (rx_char_r),
    .fields (fields)
  );

  // low bits of the two's complement field values
  assign chan_val = fields[0].neg ? 8'(8'd0 - fields[0].mag[7:0]) : fields[0].mag[7:0];
  assign type_val = fields[1].neg ? 4'(4'd0 - fields[1].mag[3:0]) : fields[1].mag[3:0];
  assign amp_val  = fields[2].neg ? 8'(8'd0 - fields[2].mag[7:0]) : fields[2].mag[7:0];
  assign off_val  = fields[3].neg ? 8'(8'd0 - fields[3].mag[7:0]) : fields[3].mag[7:0];
  assign freq_val = fields[4].neg ? 18'(18'd0 - {1'b0, fields[4].mag})
                                  : {1'b0, fields[4].mag};

  // channel match, first code has priority
  assign hit_first  = (chan_val == {4'b0, first_code});
  assign hit_second = (chan_val == {4'b0, second_code});
  assign emit       = step && is_close && (hit_first || hit_second);

  assign out_valid_next = emit ? 1'b1 : (out_stall ? out_valid : 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      wave_select    <= !hit_first;
      wave_type      <= type_val;
      wave_amplitude <= amp_val;
      wave_offset    <= off_val;
      wave_frequency <= signed'(freq_val);
    end
  end

`ifndef ASSERT_OFF
  a_result_from_close: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(in_full && (rx_char_r == CH_CLOSE)))
    else $error("result appeared without a frame end");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && is_close && out_valid && out_stall))
    else $error("input stalled without a blocked frame end");

  a_no_close_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (step && out_valid && out_stall) |-> !is_close)
    else $error("frame end processed while result register blocked");
`endif

endmodule
